// ===== rtl/mcs_pkg.sv =====
package mcs_pkg;

    localparam int PIX_W     = 8;
    localparam int NUM_W     = 2 * PIX_W;
    localparam int DIV_STEPS = PIX_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [PIX_W-1:0] FULL_SCALE = {PIX_W{1'b1}};
    localparam logic [PIX_W-1:0] ZERO_PIX   = '0;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_MEASURE = 2'd1,
        OP_MAP     = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    typedef struct packed {
        logic clear;
        logic measure;
        logic start;
        logic step;
        logic load_out;
    } t_cmd;

endpackage

// ===== rtl/mcs_ctrl.sv =====
module mcs_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_operation,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output mcs_pkg::t_cmd         o_cmd
);

    mcs_pkg::t_state             r_state, n_state;
    logic [mcs_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic                        r_out_valid, n_out_valid;
    logic                        accept;
    logic                        take;

    localparam logic [mcs_pkg::CNT_W-1:0] LAST_STEP = mcs_pkg::CNT_W'(mcs_pkg::DIV_STEPS - 1);

    assign o_in_stall  = (r_state != mcs_pkg::S_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign take        = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (take) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            mcs_pkg::S_IDLE: begin
                if (accept) begin
                    case (mcs_pkg::t_op'(i_operation))
                        mcs_pkg::OP_CLEAR:   o_cmd.clear   = 1'b1;
                        mcs_pkg::OP_MEASURE: o_cmd.measure = 1'b1;
                        mcs_pkg::OP_MAP: begin
                            o_cmd.start = 1'b1;
                            n_cnt       = '0;
                            n_state     = mcs_pkg::S_DIV;
                        end
                        default: ;
                    endcase
                end
            end
            mcs_pkg::S_DIV: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_state = mcs_pkg::S_FIN;
                end
            end
            mcs_pkg::S_FIN: begin
                if (!r_out_valid || take) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = mcs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mcs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mcs_pkg::S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || !i_out_stall))
        else $error("result loaded over a waiting result");

    a_fin_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mcs_pkg::S_DIV) && (r_cnt == LAST_STEP) |=> (r_state == mcs_pkg::S_FIN))
        else $error("divider did not finish after its last step");

    a_start_to_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> (r_state == mcs_pkg::S_DIV) && (r_cnt == '0))
        else $error("map item did not start the divider");

    a_out_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> r_out_valid && (r_state == mcs_pkg::S_IDLE))
        else $error("loaded result not presented");
`endif

endmodule

// ===== rtl/mcs_datapath.sv =====
module mcs_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mcs_pkg::t_cmd               i_cmd,
    input  logic [mcs_pkg::PIX_W-1:0]   i_pixel,
    output logic [mcs_pkg::PIX_W-1:0]   o_out_pixel
);

    logic [mcs_pkg::PIX_W-1:0] r_low, r_high;
    logic [mcs_pkg::PIX_W-1:0] r_span;
    logic [mcs_pkg::PIX_W-1:0] r_rem;
    logic [mcs_pkg::PIX_W-1:0] r_acc;
    logic                      r_sat, r_zero;
    logic [mcs_pkg::PIX_W-1:0] r_out;

    logic [mcs_pkg::PIX_W-1:0] diff;
    logic [mcs_pkg::NUM_W-1:0] num;
    logic [mcs_pkg::PIX_W:0]   trial;
    logic                      fits;

    // (pixel - low) * 255 as a shift and subtract
    assign diff  = i_pixel - r_low;
    assign num   = {diff, mcs_pkg::ZERO_PIX} - {mcs_pkg::ZERO_PIX, diff};
    assign trial = {r_rem, r_acc[mcs_pkg::PIX_W-1]};
    assign fits  = (trial >= {1'b0, r_span});

    assign o_out_pixel = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= mcs_pkg::FULL_SCALE;
            r_high <= mcs_pkg::ZERO_PIX;
        end else if (i_cmd.clear) begin
            r_low  <= mcs_pkg::FULL_SCALE;
            r_high <= mcs_pkg::ZERO_PIX;
        end else if (i_cmd.measure) begin
            if (i_pixel < r_low) begin
                r_low <= i_pixel;
            end
            if (i_pixel > r_high) begin
                r_high <= i_pixel;
            end
        end
    end

    // restoring divider: quotient bits shift into r_acc as dividend bits leave
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rem  <= num[mcs_pkg::NUM_W-1:mcs_pkg::PIX_W];
            r_acc  <= num[mcs_pkg::PIX_W-1:0];
            r_span <= r_high - r_low;
            r_sat  <= (i_pixel >= r_high);
            r_zero <= (i_pixel < r_low);
        end else if (i_cmd.step) begin
            if (fits) begin
                r_rem <= trial[mcs_pkg::PIX_W-1:0] - r_span;
                r_acc <= {r_acc[mcs_pkg::PIX_W-2:0], 1'b1};
            end else begin
                r_rem <= trial[mcs_pkg::PIX_W-1:0];
                r_acc <= {r_acc[mcs_pkg::PIX_W-2:0], 1'b0};
            end
        end
        if (i_cmd.load_out) begin
            if (r_sat) begin
                r_out <= mcs_pkg::FULL_SCALE;
            end else if (r_zero) begin
                r_out <= mcs_pkg::ZERO_PIX;
            end else begin
                r_out <= r_acc;
            end
        end
    end

`ifndef SYNTHESIS
    a_rem_below_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step && !r_sat && !r_zero |-> (r_rem < r_span))
        else $error("divider remainder out of range");
`endif

endmodule

// ===== rtl/minmax_contrast_stretch.sv =====
// Min-max contrast stretch of 8-bit grayscale pixels.
// Input channel: i_in_valid / o_in_stall with i_operation and i_pixel.
//   operation 0 clears the running low/high, 1 measures a pixel, 2 maps one.
// Output channel: o_out_valid / i_out_stall with o_out_pixel, one item per map.
// Clear and measure items leave the controller idle, so the next item can be
// taken in the following cycle. A map item runs an 8-step restoring divider
// (one quotient bit per cycle), then loads its result for o_out_valid;
// o_in_stall stays high through the divider and final states, so the next
// item is accepted only once the map result is loaded.
// The output register holds a result until taken, and the block keeps taking
// clear and measure items meanwhile. A map that finishes while the previous
// result still waits holds in its final state with o_in_stall high until
// i_out_stall drops.
// Reset (i_rst_n low, synchronous) sets low to 255, high to 0, empties the
// output register and returns the controller to idle.
module minmax_contrast_stretch (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_operation,
    input  logic [mcs_pkg::PIX_W-1:0]   i_pixel,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [mcs_pkg::PIX_W-1:0]   o_out_pixel
);

    mcs_pkg::t_cmd cmd;

    mcs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_operation (i_operation),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    mcs_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_pixel     (i_pixel),
        .o_out_pixel (o_out_pixel)
    );

endmodule
